// ----- design/substring_position_finder_defines.svh -----
// Assertion helpers for the top-level design file.
`ifndef SUBSTRING_POSITION_FINDER_DEFINES_SVH
`define SUBSTRING_POSITION_FINDER_DEFINES_SVH

// Check a plain property on the rising clock, off while reset is held.
`define SPF_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Check that a condition implies another one in the same cycle.
`define SPF_ASSERT_IMPL(label, cond, expr, msg) \
    `SPF_ASSERT(label, (cond) |-> (expr), msg)

// Check that a condition implies another one in the next cycle.
`define SPF_ASSERT_NEXT(label, cond, expr, msg) \
    `SPF_ASSERT(label, (cond) |=> (expr), msg)

`endif

// ----- design/spf_pkg.sv -----
package spf_pkg;

    localparam int MAX_PATTERN = 8;
    localparam int WIN_DEPTH   = MAX_PATTERN - 1;
    localparam int COUNT_BITS  = 16;
    localparam int LEN_W       = 4;
    localparam int PAT_W       = 64;
    localparam int OFF_W       = 16;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX  = '1;
    localparam logic [LEN_W-1:0]      LEN_LIMIT  = LEN_W'(MAX_PATTERN);

    // configuration register indexes
    localparam logic CFG_PATTERN_BYTES = 1'b0;
    localparam logic CFG_PATTERN_LEN   = 1'b1;

    typedef logic [7:0] t_byte;

    typedef struct packed {
        logic shift;   // a beat is taken this cycle
        logic clear;   // the beat ends the buffer: drop the window
        logic active;  // this cell lies inside the current pattern length
    } t_cell_ctl;

    // Pick pattern byte idx out of the packed pattern register.
    function automatic t_byte pat_byte(input logic [PAT_W-1:0] pat,
                                       input logic [LEN_W-1:0] idx);
        return pat[{idx[2:0], 3'b000} +: 8];
    endfunction

endpackage

// ----- design/spf_cell.sv -----
module spf_cell (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  spf_pkg::t_cell_ctl i_ctl,
    input  spf_pkg::t_byte     i_byte,
    input  spf_pkg::t_byte     i_pat,
    output spf_pkg::t_byte     o_byte,
    output logic               o_eq
);

    spf_pkg::t_byte r_byte;

    // advance the window one place per beat, empty it at the end of a buffer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte <= 8'h00;
        end else if (i_ctl.shift) begin
            r_byte <= i_ctl.clear ? 8'h00 : i_byte;
        end
    end

    assign o_byte = r_byte;
    // a cell outside the pattern never blocks a match
    assign o_eq   = !i_ctl.active || (r_byte == i_pat);

endmodule

// ----- design/substring_position_finder.sv -----
// Channel   Dir  Payload (tdata low bit up)                    Marker
// s_axis    in   data_byte[7:0]                                tlast = is_last
// m_axis    out  found[0], match_offset[16:1], too_long[17]    -
// cfg       in   index 0: pattern_bytes[63:0], 1: pattern_len  write enable
//
// One byte beat per cycle while m_axis takes each result; the compare is a row of window cells,
// each checking its byte against one pattern byte in the same cycle.
// A result is registered onto m_axis in the cycle after the last byte of a buffer is taken.
// Reset (synchronous, active low) clears the window, counters, configuration registers and output valid.
// s_axis stalls only while a result is held on m_axis and i_m_axis_tready is low.
module substring_position_finder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // data_byte[7:0]
    input  logic        i_s_axis_tlast,   // is_last
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [23:0] o_m_axis_tdata,   // found[0], match_offset[16:1], too_long[17]
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [63:0] i_cfg_data
);

    `include "substring_position_finder_defines.svh"

    localparam int CNT_W = spf_pkg::COUNT_BITS;
    localparam int WIN   = spf_pkg::WIN_DEPTH;
    localparam int LW    = spf_pkg::LEN_W;

    // configuration
    logic [spf_pkg::PAT_W-1:0] r_pattern;
    logic [LW-1:0]             r_plen;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pattern <= '0;
            r_plen    <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                spf_pkg::CFG_PATTERN_BYTES: r_pattern <= i_cfg_data;
                spf_pkg::CFG_PATTERN_LEN:   r_plen    <= i_cfg_data[LW-1:0];
                default:                    r_pattern <= r_pattern;
            endcase
        end
    end

    // clamp the length to the window plus the current byte
    logic [LW-1:0] w_len;
    assign w_len = (r_plen > spf_pkg::LEN_LIMIT) ? spf_pkg::LEN_LIMIT : r_plen;

    // handshake
    logic r_m_valid;
    logic w_s_acc;
    assign o_s_axis_tready = !r_m_valid || i_m_axis_tready;
    assign w_s_acc         = i_s_axis_tvalid && o_s_axis_tready;

    // window cell row: cell 0 holds the byte before the current one
    spf_pkg::t_cell_ctl w_ctl   [WIN];
    spf_pkg::t_byte     w_cbyte [WIN];
    spf_pkg::t_byte     w_cpat  [WIN];
    logic [WIN-1:0]     w_ceq;

    for (genvar j = 0; j < WIN; j++) begin : g_cell
        // cell j sees pattern byte len-2-j when that byte exists
        assign w_ctl[j].shift  = w_s_acc;
        assign w_ctl[j].clear  = i_s_axis_tlast;
        assign w_ctl[j].active = (LW'(j) + LW'(2)) <= w_len;
        assign w_cpat[j]       = spf_pkg::pat_byte(r_pattern, w_len - LW'(j) - LW'(2));

        if (j == 0) begin : g_head
            spf_cell u_cell (
                .i_clk  (i_clk),
                .i_rst_n(i_rst_n),
                .i_ctl  (w_ctl[j]),
                .i_byte (i_s_axis_tdata),
                .i_pat  (w_cpat[j]),
                .o_byte (w_cbyte[j]),
                .o_eq   (w_ceq[j])
            );
        end else begin : g_body
            spf_cell u_cell (
                .i_clk  (i_clk),
                .i_rst_n(i_rst_n),
                .i_ctl  (w_ctl[j]),
                .i_byte (w_cbyte[j-1]),
                .i_pat  (w_cpat[j]),
                .o_byte (w_cbyte[j]),
                .o_eq   (w_ceq[j])
            );
        end
    end

    // the current byte lines up with the last pattern byte
    logic w_cur_eq;
    logic w_all_eq;
    assign w_cur_eq = i_s_axis_tdata == spf_pkg::pat_byte(r_pattern, w_len - LW'(1));
    assign w_all_eq = w_cur_eq && (&w_ceq);

    // per-buffer tracking
    logic [CNT_W-1:0] r_count, n_count;
    logic             r_hit,   n_hit;
    logic [CNT_W-1:0] r_hit_off, n_hit_off;
    logic             r_ovf,   n_ovf;
    logic [CNT_W-1:0] w_count_inc;
    logic             w_sat;

    assign w_count_inc = r_count + CNT_W'(1);
    assign w_sat       = r_count == spf_pkg::COUNT_MAX;

    always_comb begin
        n_count   = r_count;
        n_hit     = r_hit;
        n_hit_off = r_hit_off;
        n_ovf     = r_ovf;
        if (w_sat) begin
            // saturated: flag it, record no new match
            n_ovf = 1'b1;
        end else begin
            // record only the first full match, once enough bytes are in
            if (!r_hit && (w_len != '0) && (w_count_inc >= CNT_W'(w_len)) && w_all_eq) begin
                n_hit     = 1'b1;
                n_hit_off = w_count_inc - CNT_W'(w_len);
            end
            n_count = w_count_inc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_hit     <= 1'b0;
            r_hit_off <= '0;
            r_ovf     <= 1'b0;
        end else if (w_s_acc) begin
            if (i_s_axis_tlast) begin
                // drop the buffer state, the result goes to the output register
                r_count   <= '0;
                r_hit     <= 1'b0;
                r_hit_off <= '0;
                r_ovf     <= 1'b0;
            end else begin
                r_count   <= n_count;
                r_hit     <= n_hit;
                r_hit_off <= n_hit_off;
                r_ovf     <= n_ovf;
            end
        end
    end

    // clamp the offset to the 16-bit result field
    logic [CNT_W+spf_pkg::OFF_W-1:0] w_off_ext;
    logic [spf_pkg::OFF_W-1:0]       w_off_sat;
    assign w_off_ext = {{spf_pkg::OFF_W{1'b0}}, n_hit_off};
    assign w_off_sat = (w_off_ext[CNT_W+spf_pkg::OFF_W-1:spf_pkg::OFF_W] != '0)
                     ? '1 : w_off_ext[spf_pkg::OFF_W-1:0];

    logic                      w_found;
    logic [spf_pkg::OFF_W-1:0] w_offset;
    assign w_found  = (w_len == '0) || n_hit;
    assign w_offset = ((w_len != '0) && n_hit) ? w_off_sat : '0;

    // output register: holds one result until the sink takes it
    logic [23:0] r_m_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (w_s_acc && i_s_axis_tlast) begin
            r_m_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s_acc && i_s_axis_tlast) begin
            r_m_data <= {6'b000000, n_ovf, w_offset, w_found};
        end
    end

    assign o_m_axis_tvalid = r_m_valid;
    assign o_m_axis_tdata  = r_m_data;

    `SPF_ASSERT_NEXT(a_clear_after_last, w_s_acc && i_s_axis_tlast,
        (r_count == '0) && !r_hit && !r_ovf, "buffer state not cleared after last beat")
    `SPF_ASSERT_IMPL(a_hit_before_count, r_hit, r_hit_off < r_count,
        "recorded match offset not below byte count")
    `SPF_ASSERT_IMPL(a_ovf_saturated, r_ovf, r_count == spf_pkg::COUNT_MAX,
        "overflow flagged while counter not saturated")
    `SPF_ASSERT_IMPL(a_result_from_last, $rose(o_m_axis_tvalid),
        $past(w_s_acc && i_s_axis_tlast), "result raised without a last beat")

endmodule

// ----- sim/substring_position_finder_tb.sv -----
// Self-checking bench for the streaming substring search block.
module substring_position_finder_tb;

    localparam int OFF_W = spf_pkg::OFF_W;
    localparam int CNT_W = spf_pkg::COUNT_BITS;

    // one beat on the byte stream
    typedef struct {
        spf_pkg::t_byte data;
        logic           last;
    } t_beat;

    // what the block reports at the end of a buffer
    typedef struct {
        logic                  found;
        logic [OFF_W-1:0]      offset;
        logic                  too_long;
    } t_search_result;

    // ---------------------------------------------------------------
    // Clock, reset and the signals driven into the block
    // ---------------------------------------------------------------
    logic           clk       = 1'b0;
    logic           rst_n     = 1'b0;
    logic           s_tvalid  = 1'b0;
    spf_pkg::t_byte s_tdata   = '0;
    logic           s_tlast   = 1'b0;
    logic           m_ready   = 1'b0;
    logic           cfg_we    = 1'b0;
    logic           cfg_index = spf_pkg::CFG_PATTERN_BYTES;
    logic [63:0]    cfg_data  = '0;

    logic        s_tready;
    logic        m_tvalid;
    logic [23:0] m_tdata;

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    substring_position_finder u_top (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tlast  (s_tlast),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_tdata),
        .i_cfg_we        (cfg_we),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data)
    );

    // ---------------------------------------------------------------
    // Stimulus queue, expected results and idling knobs
    // ---------------------------------------------------------------
    t_beat          byte_queue[$];
    t_search_result expected_results[$];
    int unsigned    send_gap_pct = 0;   // chance per cycle that the sender holds off
    int unsigned    stall_pct    = 0;   // chance per cycle that the receiver stalls
    spf_pkg::t_byte alphabet[4];        // small per-phase byte set so matches happen

    // ---------------------------------------------------------------
    // Predictor: our own copy of the search state and registers
    // ---------------------------------------------------------------
    logic [spf_pkg::PAT_W-1:0] pat_reg    = '0;
    logic [spf_pkg::LEN_W-1:0] len_reg    = '0;
    spf_pkg::t_byte            recent[spf_pkg::WIN_DEPTH];   // newest byte first
    logic [CNT_W-1:0]          byte_count = '0;
    logic                      hit_seen   = 1'b0;
    logic [CNT_W-1:0]          hit_offset = '0;
    logic                      count_ovf  = 1'b0;

    // run bookkeeping
    int unsigned error_count   = 0;
    int unsigned bytes_sent    = 0;
    int unsigned results_seen  = 0;
    int unsigned hits_seen     = 0;
    int unsigned overflows     = 0;
    int unsigned reg_writes    = 0;

    t_beat          next_beat;
    t_search_result want;
    t_search_result got;

    initial begin
        for (int i = 0; i < spf_pkg::WIN_DEPTH; i++) recent[i] = '0;
    end

    // Lengths above the pattern store are clipped to it.
    function automatic int unsigned active_len();
        return (len_reg > spf_pkg::LEN_LIMIT) ? spf_pkg::MAX_PATTERN : int'(len_reg);
    endfunction

    // Advance the search by one accepted byte; on the last byte queue the result
    // and drop the per-buffer state.
    task automatic scan_byte(input spf_pkg::t_byte b, input logic last);
        int unsigned    len;
        int unsigned    back;
        logic           match;
        spf_pkg::t_byte cand;
        t_search_result r;
        len = active_len();
        if (byte_count == spf_pkg::COUNT_MAX) begin
            // saturated counter: flag the overflow, no new match from here on
            count_ovf = 1'b1;
        end else begin
            if (!hit_seen && len > 0 && (int'(byte_count) + 1) >= len) begin
                match = 1'b1;
                for (int unsigned k = 0; k < len; k++) begin
                    back = len - 1 - k;
                    cand = (back == 0) ? b : recent[back - 1];
                    if (cand != pat_reg[8*k +: 8]) match = 1'b0;
                end
                if (match) begin
                    hit_seen   = 1'b1;
                    hit_offset = byte_count + 1'b1 - CNT_W'(len);
                end
            end
            byte_count = byte_count + 1'b1;
        end
        for (int i = spf_pkg::WIN_DEPTH - 1; i > 0; i--) recent[i] = recent[i - 1];
        recent[0] = b;
        if (last) begin
            if (len == 0) begin
                // empty pattern is always found at the start
                r.found  = 1'b1;
                r.offset = '0;
            end else if (hit_seen) begin
                r.found  = 1'b1;
                r.offset = (hit_offset > 'hFFFF) ? OFF_W'('hFFFF) : OFF_W'(hit_offset);
            end else begin
                r.found  = 1'b0;
                r.offset = '0;
            end
            r.too_long = count_ovf;
            expected_results.push_back(r);
            for (int i = 0; i < spf_pkg::WIN_DEPTH; i++) recent[i] = '0;
            byte_count = '0;
            hit_seen   = 1'b0;
            hit_offset = '0;
            count_ovf  = 1'b0;
        end
    endtask

    // ---------------------------------------------------------------
    // Driver: pull beats from the queue, hold them until taken
    // ---------------------------------------------------------------
    always @(posedge clk) begin
        if (!rst_n) begin
            s_tvalid <= 1'b0;
        end else begin
            // a beat that was on the bus with ready high has been taken at this edge
            if (s_tvalid && s_tready) begin
                scan_byte(s_tdata, s_tlast);
                bytes_sent++;
            end
            if (!s_tvalid || s_tready) begin
                if (byte_queue.size() != 0 && $urandom_range(0, 99) >= send_gap_pct) begin
                    next_beat = byte_queue.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= next_beat.data;
                    s_tlast  <= next_beat.last;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // Monitor: compare each result beat with the oldest expectation
    // ---------------------------------------------------------------
    task automatic check_field(input string name, input int unsigned exp_v,
                               input int unsigned act_v);
        if (exp_v != act_v) begin
            error_count++;
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_v, act_v);
        end
    endtask

    always @(posedge clk) begin
        if (rst_n && m_tvalid && m_ready) begin
            got.found    = m_tdata[0];
            got.offset   = m_tdata[16:1];
            got.too_long = m_tdata[17];
            results_seen++;
            if (got.found) hits_seen++;
            if (got.too_long) overflows++;
            if (expected_results.size() == 0) begin
                error_count++;
                $display({"%0t: unexpected result, expected none, ",
                          "got found %0d offset %0d too_long %0d"},
                         $time, got.found, got.offset, got.too_long);
            end else begin
                want = expected_results.pop_front();
                check_field("found", want.found, got.found);
                check_field("match_offset", want.offset, got.offset);
                check_field("too_long", want.too_long, got.too_long);
            end
        end
        m_ready <= ($urandom_range(0, 99) >= stall_pct);
    end

    // ---------------------------------------------------------------
    // Stimulus helpers
    // ---------------------------------------------------------------

    // Write one register; only called while nothing is in flight.
    task automatic write_reg(input logic idx, input logic [63:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == spf_pkg::CFG_PATTERN_BYTES) pat_reg = val;
        else                                   len_reg = val[spf_pkg::LEN_W-1:0];
        reg_writes++;
    endtask

    // Queue a short buffer of n bytes, byte 0 in the low bits.
    task automatic push_bytes(input logic [63:0] bytes, input int unsigned n);
        t_beat beat;
        for (int unsigned i = 0; i < n; i++) begin
            beat.data = bytes[8*i +: 8];
            beat.last = (i == n - 1);
            byte_queue.push_back(beat);
        end
    endtask

    // Random buffer: bytes drawn mostly from the pattern and the phase alphabet,
    // usually with the whole pattern planted, sometimes only a clipped prefix.
    task automatic push_random_buffer(input int unsigned blen);
        spf_pkg::t_byte bytes[$];
        int unsigned    eff;
        int unsigned    pos;
        int unsigned    copy_len;
        int unsigned    roll;
        int unsigned    k;
        t_beat          beat;
        eff = active_len();
        for (int unsigned i = 0; i < blen; i++) begin
            roll = $urandom_range(0, 9);
            if (roll < 4) begin
                k = $urandom_range(0, spf_pkg::MAX_PATTERN - 1);
                bytes.push_back(pat_reg[8*k +: 8]);
            end else if (roll < 8) begin
                bytes.push_back(alphabet[$urandom_range(0, 3)]);
            end else begin
                bytes.push_back(8'($urandom));
            end
        end
        roll = $urandom_range(0, 9);
        if (eff > 0 && roll < 8) begin
            copy_len = (roll < 6) ? eff : eff - 1;
            if (copy_len > 0 && blen >= copy_len) begin
                pos = $urandom_range(0, blen - copy_len);
                for (int unsigned j = 0; j < copy_len; j++) bytes[pos + j] = pat_reg[8*j +: 8];
            end
        end
        for (int unsigned i = 0; i < blen; i++) begin
            beat.data = bytes[i];
            beat.last = (i == blen - 1);
            byte_queue.push_back(beat);
        end
    endtask

    // Hold until every queued beat is taken and every result has come back,
    // then let the pipe settle.
    task automatic drain();
        do @(negedge clk);
        while (byte_queue.size() != 0 || s_tvalid || expected_results.size() != 0);
        repeat (4) @(negedge clk);
    endtask

    // ---------------------------------------------------------------
    // Test sequence
    // ---------------------------------------------------------------
    initial begin
        logic [63:0] pat;
        logic [3:0]  plen;
        int unsigned phase_beats;
        int unsigned blen;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part, no idling on either side.
        // Registers still at reset: empty pattern, found at offset zero.
        push_bytes(64'h5A, 1);
        drain();

        // Pattern with zero bytes in it: 00 FF 00.
        write_reg(spf_pkg::CFG_PATTERN_BYTES, 64'h0000_0000_0000_FF00);
        write_reg(spf_pkg::CFG_PATTERN_LEN, 64'd3);
        push_bytes(64'h00FF00, 3);                  // exact match at the start
        push_bytes(64'h00FF, 2);                    // buffer shorter than the pattern
        push_bytes(64'h00FF_0000_FF00_12, 7);       // two matches, first one reported
        push_bytes(64'hFF, 1);
        drain();

        // Length beyond the pattern store clips to the full eight bytes.
        write_reg(spf_pkg::CFG_PATTERN_BYTES, 64'h0807_0605_0403_0201);
        write_reg(spf_pkg::CFG_PATTERN_LEN, 64'd15);
        push_bytes(64'h0807_0605_0403_0201, 8);
        push_bytes(64'h0007_0605_0403_0201, 8);     // last byte differs
        drain();

        write_reg(spf_pkg::CFG_PATTERN_BYTES, '1);
        write_reg(spf_pkg::CFG_PATTERN_LEN, 64'd8);
        push_bytes('1, 8);
        push_bytes(64'h00FF_FFFF_FFFF_FFFF, 7);
        drain();

        // Random part: each phase gets its own pattern setting and one of four idling modes.
        for (int p = 0; p < 12; p++) begin
            case (p % 4)
                0: begin send_gap_pct = 0;  stall_pct = 0;  end
                1: begin send_gap_pct = 50; stall_pct = 0;  end
                2: begin send_gap_pct = 0;  stall_pct = 50; end
                default: begin send_gap_pct = 27; stall_pct = 27; end
            endcase
            for (int a = 0; a < 4; a++) alphabet[a] = 8'($urandom);
            pat = {$urandom, $urandom};
            case (p)
                0: begin pat = '1; plen = 4'd8; end
                1: plen = 4'd0;
                2: begin pat = '0; plen = 4'd15; end
                3: plen = 4'd1;
                7: plen = 4'($urandom_range(9, 15));
                default: plen = 4'($urandom_range(1, 5));
            endcase
            // keep the pattern drawn from the alphabet most of the time
            if (p > 2) begin
                for (int k = 0; k < spf_pkg::MAX_PATTERN; k++) begin
                    pat[8*k +: 8] = alphabet[$urandom_range(0, 3)];
                end
            end
            write_reg(spf_pkg::CFG_PATTERN_BYTES, pat);
            write_reg(spf_pkg::CFG_PATTERN_LEN, 64'(plen));
            phase_beats = 0;
            while (phase_beats < 137) begin
                blen = ($urandom_range(0, 19) == 0) ? $urandom_range(17, 40)
                                                    : $urandom_range(1, 16);
                push_random_buffer(blen);
                phase_beats += blen;
            end
            drain();
        end

        $display("Searched %0d bytes, %0d results checked (%0d found, %0d overflowed)",
                 bytes_sent, results_seen, hits_seen, overflows);
        $display("Pattern lengths 0 to 15 across %0d register writes and four idling modes",
                 reg_writes);
        if (error_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    // Watchdog against a hung handshake.
    initial begin
        #10_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
